// ----- hw/rtl/rhh_pkg.sv -----
// Shared types and constants of the Robin Hood hash table.
package rhh_pkg;

    // Request kinds carried in the low bits of the input user field.
    localparam logic [1:0] REQ_PUT    = 2'd0;
    localparam logic [1:0] REQ_GET    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_DUP      = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // A hash of zero marks an empty slot, so a zero input hash is replaced.
    localparam logic [31:0] SUBST_HASH = 32'h8000_0000;

    // Hash bits folded into the home-slot remainder per cycle.
    localparam int unsigned MOD_BITS_PER_STEP = 4;

    localparam logic [6:0] LOAD_LIMIT_RESET = 7'd51;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HOME,
        S_RD,
        S_EV,
        S_SRD,
        S_SEV,
        S_SFIN,
        S_DONE
    } t_state;

endpackage

// ----- hw/rtl/robin_hood_hash_table.sv -----
// Top level of the Robin Hood hash table with backward-shift deletion.
//
//  Channel  | Direction | Transfer when            | Payload
//  ---------+-----------+--------------------------+----------------------------------
//  s_axis   | in        | s_axis_tvalid & tready   | request: key, hash, value, kind
//  m_axis   | out       | m_axis_tvalid & tready   | result: status, value, used count
//  cfg      | in        | i_cfg_we                 | load limit
//
// After its transfer a request waits in S_HOME while the serial remainder
// unit reduces its hash to a home slot, then visits slots through the slot
// memory, each in S_RD (read) and then S_EV (evaluate and write). A remove
// that hits then runs the backward shift, S_SRD and S_SEV for each slot
// examined, the slot that stops it included, and S_SFIN to empty the last
// slot. The result is handed over in S_DONE and the next transfer taken in
// S_IDLE. After reset a clearing pass writes every slot empty, with
// s_axis_tready low; load limit writes are taken throughout. A request is
// taken while an earlier result still waits in the output register, and a
// stalled output holds the next result in S_DONE.
module robin_hood_hash_table #(
    parameter int unsigned TABLE_DEPTH = 64,
    parameter int unsigned KEY_WIDTH   = 32,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] key, [63:32] key_hash, [95:64] value
    input  logic [95:0] s_axis_tdata,
    // [1:0] req_type, [2] can_replace
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] value_out, [38:32] used_count, [39] zero fill
    output logic [39:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]  m_axis_tuser
);
    import rhh_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = AW + 1;
    localparam int unsigned KW = KEY_WIDTH;
    localparam int unsigned VW = VALUE_WIDTH;
    // Slot entry layout from the lowest bit: hash, home slot, key, value.
    localparam int unsigned EW = 32 + AW + KW + VW;
    localparam int unsigned HO = 32;
    localparam int unsigned KO = 32 + AW;
    localparam int unsigned VO = 32 + AW + KW;

    t_state          r_state, n_state;
    logic [1:0]      r_req, n_req;
    logic [31:0]     r_h, n_h;
    logic [KW-1:0]   r_k, n_k;
    logic [VW-1:0]   r_v, n_v;
    logic            r_rep, n_rep;
    logic [AW-1:0]   r_chome, n_chome;
    logic [AW-1:0]   r_idx, n_idx;
    logic [AW-1:0]   r_cur, n_cur;
    logic [AW:0]     r_i, n_i;
    logic [AW:0]     r_probe, n_probe;
    logic [AW-1:0]   r_dist, n_dist;
    logic [1:0]      r_status, n_status;
    logic [31:0]     r_vout, n_vout;
    logic [CW-1:0]   r_count, n_count;
    logic [6:0]      r_limit;
    logic            r_ovalid, n_ovalid;
    logic [1:0]      r_ostatus, n_ostatus;
    logic [31:0]     r_ovalue, n_ovalue;
    logic [6:0]      r_oused, n_oused;

    logic            mod_start;
    logic            mod_done;
    logic [AW-1:0]   mod_rem;
    logic [31:0]     in_hash;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [EW-1:0]   mem_wdata;
    logic [AW-1:0]   mem_raddr;
    logic [EW-1:0]   mem_rdata;

    logic [31:0]     e_hash;
    logic [AW-1:0]   e_home;
    logic [KW-1:0]   e_key;
    logic [VW-1:0]   e_value;
    logic            e_empty;
    logic            e_match;
    logic [AW-1:0]   cur_next;

    // Distance of a resident entry from its home slot, wrapping at the end.
    function automatic logic [AW-1:0] slot_dist(input logic [AW-1:0] idx,
                                                input logic [AW-1:0] home);
        logic [AW:0] wrapped;
        wrapped = (AW+1)'(idx) + (AW+1)'(TABLE_DEPTH) - (AW+1)'(home);
        if (home <= idx) begin
            return idx - home;
        end
        return wrapped[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] idx);
        return (idx == AW'(TABLE_DEPTH - 1)) ? '0 : idx + AW'(1);
    endfunction

    assign in_hash   = (s_axis_tdata[63:32] == '0) ? SUBST_HASH : s_axis_tdata[63:32];
    assign mod_start = s_axis_tvalid && s_axis_tready;

    rhh_mod_unit #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_x     (in_hash),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    rhh_slot_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .W     (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign e_hash   = mem_rdata[31:0];
    assign e_home   = mem_rdata[HO +: AW];
    assign e_key    = mem_rdata[KO +: KW];
    assign e_value  = mem_rdata[VO +: VW];
    assign e_empty  = (e_hash == '0);
    assign e_match  = (e_hash == r_h) && (e_key == r_k);
    assign cur_next = slot_next(r_cur);

    assign s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_idx    <= '0;
            r_count  <= '0;
            r_limit  <= LOAD_LIMIT_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_h       <= n_h;
        r_k       <= n_k;
        r_v       <= n_v;
        r_rep     <= n_rep;
        r_chome   <= n_chome;
        r_cur     <= n_cur;
        r_i       <= n_i;
        r_probe   <= n_probe;
        r_dist    <= n_dist;
        r_status  <= n_status;
        r_vout    <= n_vout;
        r_ostatus <= n_ostatus;
        r_ovalue  <= n_ovalue;
        r_oused   <= n_oused;
    end

    always_comb begin
        logic [AW-1:0] d;
        logic [AW-1:0] sd;
        logic [AW-1:0] dnew;
        d    = slot_dist(r_idx, e_home);
        sd   = slot_dist(cur_next, e_home);
        dnew = e_empty ? r_dist : d;

        n_state   = r_state;
        n_req     = r_req;
        n_h       = r_h;
        n_k       = r_k;
        n_v       = r_v;
        n_rep     = r_rep;
        n_chome   = r_chome;
        n_idx     = r_idx;
        n_cur     = r_cur;
        n_i       = r_i;
        n_probe   = r_probe;
        n_dist    = r_dist;
        n_status  = r_status;
        n_vout    = r_vout;
        n_count   = r_count;
        n_ostatus = r_ostatus;
        n_ovalue  = r_ovalue;
        n_oused   = r_oused;
        n_ovalid  = r_ovalid && !m_axis_tready;

        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = {r_v, r_k, r_chome, r_h};
        mem_raddr = r_idx;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                n_idx     = r_idx + AW'(1);
                if (r_idx == AW'(TABLE_DEPTH - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_req   = s_axis_tuser[1:0];
                    n_rep   = s_axis_tuser[2];
                    n_h     = in_hash;
                    n_k     = KW'(s_axis_tdata[31:0]);
                    n_v     = VW'(s_axis_tdata[95:64]);
                    n_state = S_HOME;
                end
            end
            S_HOME: begin
                if (mod_done) begin
                    n_chome  = mod_rem;
                    n_idx    = mod_rem;
                    n_i      = '0;
                    n_probe  = '0;
                    n_dist   = '0;
                    n_vout   = '0;
                    n_status = ST_NOTFOUND;
                    n_state  = S_DONE;
                    unique case (r_req) inside
                        REQ_PUT: begin
                            if (32'(r_count) >= 32'(r_limit) ||
                                32'(r_count) >= 32'(TABLE_DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        REQ_GET, REQ_REMOVE: begin
                            if (r_count != '0) begin
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                if (r_req == REQ_PUT) begin
                    if (e_empty) begin
                        mem_we   = 1'b1;
                        n_count  = r_count + CW'(1);
                        n_status = ST_OK;
                        n_state  = S_DONE;
                    end else if (e_match) begin
                        n_state = S_DONE;
                        if (r_rep) begin
                            mem_we   = 1'b1;
                            n_status = ST_OK;
                        end else begin
                            n_status = ST_DUP;
                        end
                    end else begin
                        // Take the slot from a richer resident and carry it on.
                        if (r_probe > (AW+1)'(d)) begin
                            mem_we  = 1'b1;
                            n_h     = e_hash;
                            n_k     = e_key;
                            n_v     = e_value;
                            n_chome = e_home;
                            n_probe = (AW+1)'(d) + (AW+1)'(1);
                        end else begin
                            n_probe = r_probe + (AW+1)'(1);
                        end
                        n_idx = slot_next(r_idx);
                        n_i   = r_i + (AW+1)'(1);
                        if (r_i == (AW+1)'(TABLE_DEPTH - 1)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                end else begin
                    if (e_match) begin
                        if (r_req == REQ_GET) begin
                            n_vout   = 32'(e_value);
                            n_status = ST_OK;
                            n_state  = S_DONE;
                        end else begin
                            n_cur   = r_idx;
                            n_i     = '0;
                            n_state = S_SRD;
                        end
                    end else begin
                        // An empty slot keeps the distance of the last resident seen.
                        n_dist = dnew;
                        n_idx  = slot_next(r_idx);
                        n_i    = r_i + (AW+1)'(1);
                        if (r_i > (AW+1)'(dnew) ||
                            r_i == (AW+1)'(TABLE_DEPTH - 1)) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_SRD: begin
                mem_raddr = cur_next;
                if (r_i == (AW+1)'(TABLE_DEPTH - 1)) begin
                    n_state = S_SFIN;
                end else begin
                    n_state = S_SEV;
                end
            end
            S_SEV: begin
                if (e_empty || sd == '0) begin
                    n_state = S_SFIN;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cur;
                    mem_wdata = mem_rdata;
                    n_cur     = cur_next;
                    n_i       = r_i + (AW+1)'(1);
                    n_state   = S_SRD;
                end
            end
            S_SFIN: begin
                mem_we    = 1'b1;
                mem_waddr = r_cur;
                mem_wdata = '0;
                n_count   = r_count - CW'(1);
                n_status  = ST_OK;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_ovalue  = r_vout;
                    n_oused   = 7'(r_count);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_oused, r_ovalue};
    assign m_axis_tuser  = r_ostatus;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(TABLE_DEPTH))
        else $error("occupied count exceeds table depth");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while the previous one is in progress");

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !m_axis_tvalid)
        else $error("result offered during the clearing pass");

    a_dup_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EV && r_req == REQ_PUT && !e_empty && e_match |=>
        r_count == $past(r_count))
        else $error("occupied count changed on a key match");

endmodule

// ----- hw/rtl/rhh_mod_unit.sv -----
// Serial remainder unit: reduces a 32-bit hash modulo the table depth.
module rhh_mod_unit #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [31:0]   i_x,
    output logic          o_done,
    output logic [AW-1:0] o_rem
);
    import rhh_pkg::*;

    localparam int unsigned STEPS = 32 / MOD_BITS_PER_STEP;
    localparam int unsigned SW    = $clog2(STEPS + 1);

    logic [31:0]   r_x;
    logic [AW:0]   r_rem;
    logic [SW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [AW:0]   n_rem;

    // Restoring remainder, one hash bit per inner step, MSB first.
    always_comb begin
        logic [AW:0] t;
        t = r_rem;
        for (int b = 0; b < MOD_BITS_PER_STEP; b++) begin
            t = {t[AW-1:0], r_x[31-b]};
            if (t >= (AW+1)'(DEPTH)) begin
                t = t - (AW+1)'(DEPTH);
            end
        end
        n_rem = t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_x    <= i_x;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_x   <= r_x << MOD_BITS_PER_STEP;
                r_cnt <= r_cnt + SW'(1);
                if (r_cnt == SW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[AW-1:0];

endmodule

// ----- hw/rtl/rhh_slot_mem.sv -----
// Slot memory: one write port and one registered read port.
module rhh_slot_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6,
    parameter int unsigned W     = 102
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- tb/sv/tb_robin_hood_hash_table.sv -----
// Self-checking testbench for the Robin Hood hash table: directed and random requests.
module tb_robin_hood_hash_table;
    import rhh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam int LIMIT_CYCLES = 5000000;

    typedef struct packed {
        logic [1:0]  kind;
        logic        can_replace;
        logic [31:0] key;
        logic [31:0] hash;
        logic [31:0] value;
    } t_request;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value_out;
        logic [6:0]  used;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [6:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    robin_hood_hash_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the table, updated as each request is accepted.
    logic [31:0] tbl_hash [DEPTH];
    logic [31:0] tbl_key [DEPTH];
    logic [31:0] tbl_value [DEPTH];
    int unsigned tbl_used;
    logic [6:0]  load_limit;

    t_request pending_reqs[$];
    t_answer  expected_answers[$];
    int       error_count = 0;
    int       answer_count = 0;
    int       cycle_count = 0;
    bit       quiet_phase = 1'b0;   // while set, neither side idles
    bit       sender_hold = 1'b0;

    // Key pool kept small so that gets and removes hit, and hashes collide.
    logic [31:0] pool_key [16];
    logic [31:0] pool_hash [16];

    function automatic int unsigned home_slot(logic [31:0] h);
        return h % DEPTH;
    endfunction

    function automatic int unsigned slot_distance(int unsigned idx);
        int unsigned home;
        home = home_slot(tbl_hash[idx]);
        return (home <= idx) ? idx - home : idx + DEPTH - home;
    endfunction

    function automatic bit find_slot(logic [31:0] h, logic [31:0] k, output int unsigned at);
        int unsigned idx;
        int unsigned stop_dist;
        idx = home_slot(h);
        stop_dist = 0;
        at = 0;
        if (tbl_used == 0) return 1'b0;
        for (int unsigned i = 0; i < DEPTH; i++) begin
            if (tbl_hash[idx] == h && tbl_key[idx] == k) begin
                at = idx;
                return 1'b1;
            end
            if (tbl_hash[idx] != 0) stop_dist = slot_distance(idx);
            if (i > stop_dist) break;
            idx = (idx + 1) % DEPTH;
        end
        return 1'b0;
    endfunction

    function automatic logic [1:0] table_put(logic [31:0] h, logic [31:0] k,
                                             logic [31:0] v, bit can_rep);
        int unsigned idx;
        int unsigned probe;
        int unsigned d;
        logic [31:0] th, tk, tv;
        idx = home_slot(h);
        probe = 0;
        if (tbl_used >= load_limit || tbl_used >= DEPTH) return ST_FULL;
        for (int unsigned i = 0; i < DEPTH; i++) begin
            if (tbl_hash[idx] == 0) begin
                tbl_hash[idx] = h;
                tbl_key[idx] = k;
                tbl_value[idx] = v;
                tbl_used++;
                return ST_OK;
            end
            if (tbl_hash[idx] == h && tbl_key[idx] == k) begin
                if (!can_rep) return ST_DUP;
                tbl_value[idx] = v;
                return ST_OK;
            end
            d = slot_distance(idx);
            // The carried entry is poorer than the resident: swap them.
            if (probe > d) begin
                th = tbl_hash[idx];
                tk = tbl_key[idx];
                tv = tbl_value[idx];
                tbl_hash[idx] = h;
                tbl_key[idx] = k;
                tbl_value[idx] = v;
                h = th;
                k = tk;
                v = tv;
                probe = d;
            end
            probe++;
            idx = (idx + 1) % DEPTH;
        end
        return ST_FULL;
    endfunction

    function automatic logic [1:0] table_remove(logic [31:0] h, logic [31:0] k);
        int unsigned cur;
        int unsigned nx;
        if (!find_slot(h, k, cur)) return ST_NOTFOUND;
        // Backward shift until an empty slot or an entry at its home.
        for (int unsigned i = 0; i + 1 < DEPTH; i++) begin
            nx = (cur + 1) % DEPTH;
            if (tbl_hash[nx] == 0 || slot_distance(nx) == 0) break;
            tbl_hash[cur] = tbl_hash[nx];
            tbl_key[cur] = tbl_key[nx];
            tbl_value[cur] = tbl_value[nx];
            cur = nx;
        end
        tbl_hash[cur] = 0;
        tbl_used--;
        return ST_OK;
    endfunction

    function automatic t_answer table_request(t_request r);
        t_answer a;
        logic [31:0] h;
        int unsigned at;
        h = (r.hash == 0) ? SUBST_HASH : r.hash;
        a.status = ST_NOTFOUND;
        a.value_out = '0;
        case (r.kind)
            REQ_PUT: begin
                a.status = table_put(h, r.key, r.value, r.can_replace);
            end
            REQ_GET: begin
                if (find_slot(h, r.key, at)) begin
                    a.status = ST_OK;
                    a.value_out = tbl_value[at];
                end
            end
            REQ_REMOVE: begin
                a.status = table_remove(h, r.key);
            end
            default: ;
        endcase
        a.used = tbl_used[6:0];
        return a;
    endfunction

    // Sender: presents queued requests, idling at random outside quiet phases and while sender_hold is set.
    always @(posedge i_clk) begin
        t_request r;
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_answers.push_back(table_request(pending_reqs.pop_front()));
            end
            if ((!s_axis_tvalid || s_axis_tready)) begin
                if (pending_reqs.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0)
                    && !sender_hold && (quiet_phase || $urandom_range(99) >= 22)) begin
                    r = pending_reqs[0];
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {r.value, r.hash, r.key};
                    s_axis_tuser <= {r.can_replace, r.kind};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random backpressure outside quiet phases, checks each transfer against the oldest prediction.
    always @(posedge i_clk) begin
        t_answer want;
        int errs;
        errs = 0;
        if (i_rst_n) begin
            m_axis_tready <= quiet_phase || ($urandom_range(99) >= 22);
            if (m_axis_tvalid && m_axis_tready) begin
                answer_count <= answer_count + 1;
                if (expected_answers.size() == 0) begin
                    $display("%0t: unexpected result status=%0d value=%h used=%0d", $time,
                             m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[38:32]);
                    errs++;
                end else begin
                    want = expected_answers.pop_front();
                    if (m_axis_tuser !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, m_axis_tuser);
                        errs++;
                    end
                    if (m_axis_tdata[31:0] !== want.value_out) begin
                        $display("%0t: value_out expected %h actual %h", $time,
                                 want.value_out, m_axis_tdata[31:0]);
                        errs++;
                    end
                    if (m_axis_tdata[38:32] !== want.used) begin
                        $display("%0t: used_count expected %0d actual %0d", $time,
                                 want.used, m_axis_tdata[38:32]);
                        errs++;
                    end
                end
                if (errs != 0) begin
                    error_count <= error_count + errs;
                end
            end
        end
    end

    // Timeout watchdog.
    always @(posedge i_clk) begin
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_answers.size());
            $display("[robin_hood_hash_table] ERROR");
            $finish;
        end
    end

    task automatic queue_request(logic [1:0] kind, logic [31:0] key, logic [31:0] hash,
                                 logic [31:0] value, bit can_rep);
        t_request r;
        r.kind = kind;
        r.key = key;
        r.hash = hash;
        r.value = value;
        r.can_replace = can_rep;
        pending_reqs.push_back(r);
    endtask

    // Waits until every queued request has been answered, then lets the
    // block settle before a register write.
    task automatic drain();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_answers.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [6:0] lim);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= lim;
        load_limit = lim;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly pool keys (hits, collisions), some fully random requests.
    task automatic queue_random(int n, int pool_span);
        int p;
        logic [1:0] kind;
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(pool_span - 1);
            kind = logic'($urandom_range(99) < 3) ? 2'd3 : 2'($urandom_range(2));
            if ($urandom_range(9) == 0)
                queue_request(2'($urandom_range(3)), $urandom, $urandom, $urandom,
                              1'($urandom_range(1)));
            else
                queue_request(kind, pool_key[p], pool_hash[p], $urandom,
                              1'($urandom_range(1)));
        end
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) tbl_hash[i] = '0;
        tbl_used = 0;
        load_limit = LOAD_LIMIT_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero hash substitution, colliding homes, duplicates,
        // replace, misses, unused request kind, wrap around the last slot.
        queue_request(REQ_GET, 32'h0, 32'h0, 32'h0, 1'b0);
        queue_request(REQ_REMOVE, 32'h0, 32'h0, 32'h0, 1'b0);
        queue_request(REQ_PUT, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0);
        queue_request(REQ_GET, 32'h0, SUBST_HASH, 32'h0, 1'b0);
        queue_request(REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0);
        queue_request(REQ_PUT, 32'h1, 32'h0000_003F, 32'h1, 1'b0);
        queue_request(REQ_PUT, 32'h2, 32'h0000_007F, 32'h2, 1'b0);
        queue_request(REQ_PUT, 32'h3, 32'h0000_0000, 32'h3, 1'b1);
        queue_request(REQ_PUT, 32'h1, 32'h0000_003F, 32'hAAAA_5555, 1'b0);
        queue_request(REQ_PUT, 32'h1, 32'h0000_003F, 32'h5555_AAAA, 1'b1);
        queue_request(REQ_GET, 32'h1, 32'h0000_003F, 32'h0, 1'b0);
        queue_request(REQ_GET, 32'h2, 32'h0000_007F, 32'h0, 1'b0);
        queue_request(REQ_GET, 32'h9, 32'h0000_003F, 32'h0, 1'b0);
        queue_request(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        queue_request(REQ_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0);
        queue_request(REQ_GET, 32'h2, 32'h0000_007F, 32'h0, 1'b0);
        queue_request(REQ_REMOVE, 32'h1, 32'h0000_003F, 32'h0, 1'b0);
        queue_request(REQ_GET, 32'h3, 32'h0, 32'h0, 1'b0);
        drain();

        // Key pool: a few hashes share home slots to force long probes.
        for (int i = 0; i < 16; i++) begin
            pool_key[i] = $urandom;
            pool_hash[i] = (i < 6) ? {24'($urandom_range(255)), 2'b00, 6'd5} : $urandom;
        end
        pool_hash[15] = '0;

        // Load limit of zero refuses every put.
        write_limit(7'd0);
        queue_random(40, 16);
        drain();

        // Full table: limit above the depth, filled with fresh keys.
        write_limit(7'd127);
        quiet_phase = 1'b1;
        for (int i = 0; i < 70; i++)
            queue_request(REQ_PUT, 32'h100 + i, $urandom, i, 1'b0);
        queue_random(60, 16);
        drain();
        quiet_phase = 1'b0;
        for (int i = 0; i < 70; i++)
            queue_request(REQ_REMOVE, 32'h100 + i, 32'h0, 32'h0, 1'b0);
        drain();

        // Sender holds with requests still queued until all answers are back.
        queue_random(20, 16);
        repeat (60) @(posedge i_clk);
        sender_hold = 1'b1;
        while (s_axis_tvalid || expected_answers.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        sender_hold = 1'b0;
        drain();

        // Random phases over several limits, ending at the reset value.
        foreach (pool_key[i]) ;
        for (int ph = 0; ph < 5; ph++) begin
            write_limit(ph == 0 ? 7'd64 : ph == 1 ? 7'd8 : ph == 2 ? 7'd1 :
                        ph == 3 ? 7'd33 : LOAD_LIMIT_RESET);
            for (int i = 0; i < 16; i++) begin
                pool_key[i] = (i < 4) ? {1'($urandom_range(1)), 31'(i)} : $urandom;
                pool_hash[i] = (i < 8) ? {26'($urandom), 6'(ph)} : $urandom;
            end
            pool_hash[$urandom_range(15)] = '0;
            queue_random(320, 16);
            drain();
        end
        repeat (50) @(posedge i_clk);

        $display("Covered %0d checked results over load limits 0, 1, 8, 33, 51, 64, 127,",
                 answer_count);
        $display("including a full table, collisions, duplicates and backward shifts.");
        if (error_count == 0 && expected_answers.size() == 0) begin
            $display("[robin_hood_hash_table] OK");
        end else begin
            $display("[robin_hood_hash_table] ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/rhh_pkg.sv
hw/rtl/rhh_mod_unit.sv
hw/rtl/rhh_slot_mem.sv
hw/rtl/robin_hood_hash_table.sv
tb/sv/tb_robin_hood_hash_table.sv
